// ----- hdl/dcd_pkg.sv -----
package dcd_pkg;

  localparam int unsigned VERTEX_COUNT_W   = 9;
  localparam int unsigned VERTEX_W         = 8;
  localparam int unsigned STATUS_W         = 2;
  localparam int unsigned DEF_MAX_VERTICES = 256;
  localparam int unsigned DEF_MAX_EDGES    = 1024;
  localparam logic [VERTEX_COUNT_W-1:0] VERTEX_COUNT_RESET = 9'd256;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_OVERFLOW = 2'd1,
    STATUS_RANGE    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    COLOR_UNVISITED = 2'd0,
    COLOR_ON_STACK  = 2'd1,
    COLOR_DONE      = 2'd2
  } color_e;

endpackage

// ----- hdl/dcd_edge_if.sv -----
interface dcd_edge_if;
  logic                          valid;
  logic                          ready;
  logic [dcd_pkg::VERTEX_W-1:0]  src_vertex;
  logic [dcd_pkg::VERTEX_W-1:0]  dst_vertex;
  logic                          last_edge;

  modport source (output valid, src_vertex, dst_vertex, last_edge, input ready);
  modport sink   (input valid, src_vertex, dst_vertex, last_edge, output ready);
endinterface

// ----- hdl/dcd_result_if.sv -----
interface dcd_result_if;
  logic                          valid;
  logic                          ready;
  logic                          has_cycle;
  logic [dcd_pkg::STATUS_W-1:0]  status;

  modport source (output valid, has_cycle, status, input ready);
  modport sink   (input valid, has_cycle, status, output ready);
endinterface

// ----- hdl/dcd_ram.sv -----
module dcd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/dcd_ctrl.sv -----
module dcd_ctrl #(
  parameter int unsigned MAX_VERTICES = dcd_pkg::DEF_MAX_VERTICES,
  parameter int unsigned MAX_EDGES    = dcd_pkg::DEF_MAX_EDGES,
  localparam int unsigned VW  = $clog2(MAX_VERTICES),
  localparam int unsigned CW  = $clog2(MAX_VERTICES + 1),
  localparam int unsigned EW  = $clog2(MAX_EDGES + 1),
  localparam int unsigned EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [CW-1:0]     vcount_i,
  dcd_edge_if.sink          edge_i,
  dcd_result_if.source      result_o,
  output logic              head_we_o,
  output logic [VW-1:0]     head_waddr_o,
  output logic [EW-1:0]     head_wdata_o,
  output logic [VW-1:0]     head_raddr_o,
  input  logic [EW-1:0]     head_rdata_i,
  output logic              color_we_o,
  output logic [VW-1:0]     color_waddr_o,
  output logic [1:0]        color_wdata_o,
  output logic [VW-1:0]     color_raddr_o,
  input  logic [1:0]        color_rdata_i,
  output logic              edge_we_o,
  output logic [EAW-1:0]    edge_waddr_o,
  output logic [EW+VW-1:0]  edge_wdata_o,
  output logic [EAW-1:0]    edge_raddr_o,
  input  logic [EW+VW-1:0]  edge_rdata_i,
  output logic              stack_we_o,
  output logic [VW-1:0]     stack_waddr_o,
  output logic [VW+EW-1:0]  stack_wdata_o,
  output logic [VW-1:0]     stack_raddr_o,
  input  logic [VW+EW-1:0]  stack_rdata_i
);
  import dcd_pkg::*;

  localparam int unsigned NW = (CW > VERTEX_COUNT_W) ? CW : VERTEX_COUNT_W;
  localparam logic [EW-1:0] EDGE_NULL = EW'(MAX_EDGES);
  localparam logic [CW-1:0] VMAX      = CW'(MAX_VERTICES);
  localparam logic [CW-1:0] VLAST     = CW'(MAX_VERTICES - 1);

  localparam logic [3:0] ST_CLEAR    = 4'd0;
  localparam logic [3:0] ST_LOAD     = 4'd1;
  localparam logic [3:0] ST_WAIT     = 4'd2;
  localparam logic [3:0] ST_ROOT     = 4'd3;
  localparam logic [3:0] ST_ROOT_CHK = 4'd4;
  localparam logic [3:0] ST_STEP     = 4'd5;
  localparam logic [3:0] ST_POP      = 4'd6;
  localparam logic [3:0] ST_EDGE     = 4'd7;
  localparam logic [3:0] ST_TGT      = 4'd8;
  localparam logic [3:0] ST_FINISH   = 4'd9;

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] clr_q, clr_d;
  logic [EW-1:0] stored_q, stored_d;
  status_e       err_q, err_d;
  logic [CW-1:0] n_q, n_d;
  logic [CW-1:0] root_q, root_d;
  logic [CW-1:0] depth_q, depth_d;
  logic [VW-1:0] top_v_q, top_v_d;
  logic [EW-1:0] top_cur_q, top_cur_d;
  logic [VW-1:0] tgt_q, tgt_d;
  logic          cyc_q, cyc_d;

  logic          ld_v_q, ld_v_d;
  logic [VW-1:0] ld_src_q, ld_src_d;
  logic [VW-1:0] ld_dst_q, ld_dst_d;
  logic [EW-1:0] ld_idx_q, ld_idx_d;
  logic          fwd_v_q, fwd_v_d;
  logic [EW-1:0] fwd_idx_q, fwd_idx_d;

  logic          out_v_q, out_v_d;
  logic          out_cyc_q, out_cyc_d;
  status_e       out_st_q, out_st_d;

  logic          acc;
  logic          range_ok;
  logic          full;
  logic [NW-1:0] src_ext, dst_ext, n_ext;
  logic [VW-1:0] src_idx, dst_idx;
  logic [CW-1:0] depth_m1, depth_m2;
  logic [EW-1:0] edge_next;
  logic [VW-1:0] edge_tgt;
  color_e        color_rd;

  assign edge_i.ready = (state_q == ST_LOAD);
  assign acc          = edge_i.valid && edge_i.ready;

  assign src_ext  = NW'(edge_i.src_vertex);
  assign dst_ext  = NW'(edge_i.dst_vertex);
  assign n_ext    = NW'(vcount_i);
  assign src_idx  = src_ext[VW-1:0];
  assign dst_idx  = dst_ext[VW-1:0];
  assign range_ok = (src_ext < n_ext) && (dst_ext < n_ext);
  assign full     = (stored_q >= EDGE_NULL);

  assign depth_m1  = depth_q - CW'(1);
  assign depth_m2  = depth_q - CW'(2);
  assign edge_next = edge_rdata_i[EW+VW-1:VW];
  assign edge_tgt  = edge_rdata_i[VW-1:0];
  assign color_rd  = color_e'(color_rdata_i);

  assign result_o.valid     = out_v_q;
  assign result_o.has_cycle = out_cyc_q;
  assign result_o.status    = out_st_q;

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    stored_d  = stored_q;
    err_d     = err_q;
    n_d       = n_q;
    root_d    = root_q;
    depth_d   = depth_q;
    top_v_d   = top_v_q;
    top_cur_d = top_cur_q;
    tgt_d     = tgt_q;
    cyc_d     = cyc_q;
    ld_v_d    = 1'b0;
    ld_src_d  = ld_src_q;
    ld_dst_d  = ld_dst_q;
    ld_idx_d  = ld_idx_q;
    fwd_v_d   = fwd_v_q;
    fwd_idx_d = fwd_idx_q;
    out_v_d   = out_v_q && !result_o.ready;
    out_cyc_d = out_cyc_q;
    out_st_d  = out_st_q;

    head_we_o     = 1'b0;
    head_waddr_o  = ld_src_q;
    head_wdata_o  = ld_idx_q;
    head_raddr_o  = src_idx;
    color_we_o    = 1'b0;
    color_waddr_o = top_v_q;
    color_wdata_o = COLOR_DONE;
    color_raddr_o = src_idx;
    edge_we_o     = ld_v_q;
    edge_waddr_o  = ld_idx_q[EAW-1:0];
    edge_wdata_o  = {(fwd_v_q ? fwd_idx_q : head_rdata_i), ld_dst_q};
    edge_raddr_o  = top_cur_q[EAW-1:0];
    stack_we_o    = 1'b0;
    stack_waddr_o = depth_m1[VW-1:0];
    stack_wdata_o = {top_v_q, top_cur_q};
    stack_raddr_o = depth_m2[VW-1:0];

    // pending edge from the load stage links into its list
    if (ld_v_q) begin
      head_we_o = 1'b1;
    end

    unique case (state_q)
      ST_CLEAR: begin
        head_we_o     = 1'b1;
        head_waddr_o  = clr_q[VW-1:0];
        head_wdata_o  = EDGE_NULL;
        color_we_o    = 1'b1;
        color_waddr_o = clr_q[VW-1:0];
        color_wdata_o = COLOR_UNVISITED;
        clr_d         = clr_q + CW'(1);
        if (clr_q == VLAST) begin
          clr_d    = '0;
          stored_d = '0;
          err_d    = STATUS_OK;
          state_d  = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (acc) begin
          priority if (!range_ok) begin
            if (err_q == STATUS_OK) err_d = STATUS_RANGE;
          end else if (full) begin
            if (err_q == STATUS_OK) err_d = STATUS_OVERFLOW;
          end else begin
            ld_v_d    = 1'b1;
            ld_src_d  = src_idx;
            ld_dst_d  = dst_idx;
            ld_idx_d  = stored_q;
            stored_d  = stored_q + EW'(1);
            fwd_v_d   = ld_v_q && (ld_src_q == src_idx);
            fwd_idx_d = ld_idx_q;
          end
          if (edge_i.last_edge) begin
            n_d     = vcount_i;
            state_d = ST_WAIT;
          end
        end
      end
      ST_WAIT: begin
        root_d = '0;
        cyc_d  = 1'b0;
        if (err_q != STATUS_OK) begin
          state_d = ST_FINISH;
        end else begin
          state_d = ST_ROOT;
        end
      end
      ST_ROOT: begin
        head_raddr_o  = root_q[VW-1:0];
        color_raddr_o = root_q[VW-1:0];
        if (root_q == n_q) begin
          cyc_d   = 1'b0;
          state_d = ST_FINISH;
        end else begin
          state_d = ST_ROOT_CHK;
        end
      end
      ST_ROOT_CHK: begin
        if (color_rd != COLOR_UNVISITED) begin
          root_d  = root_q + CW'(1);
          state_d = ST_ROOT;
        end else begin
          color_we_o    = 1'b1;
          color_waddr_o = root_q[VW-1:0];
          color_wdata_o = COLOR_ON_STACK;
          top_v_d       = root_q[VW-1:0];
          top_cur_d     = head_rdata_i;
          depth_d       = CW'(1);
          state_d       = ST_STEP;
        end
      end
      ST_STEP: begin
        if (top_cur_q >= EDGE_NULL) begin
          color_we_o    = 1'b1;
          color_waddr_o = top_v_q;
          color_wdata_o = COLOR_DONE;
          depth_d       = depth_m1;
          if (depth_q == CW'(1)) begin
            root_d  = root_q + CW'(1);
            state_d = ST_ROOT;
          end else begin
            state_d = ST_POP;
          end
        end else begin
          state_d = ST_EDGE;
        end
      end
      ST_POP: begin
        top_v_d   = stack_rdata_i[VW+EW-1:EW];
        top_cur_d = stack_rdata_i[EW-1:0];
        state_d   = ST_STEP;
      end
      ST_EDGE: begin
        top_cur_d     = edge_next;
        tgt_d         = edge_tgt;
        head_raddr_o  = edge_tgt;
        color_raddr_o = edge_tgt;
        state_d       = ST_TGT;
      end
      ST_TGT: begin
        state_d = ST_STEP;
        unique case (color_rd)
          COLOR_UNVISITED: begin
            if (depth_q < VMAX) begin
              stack_we_o    = 1'b1;
              color_we_o    = 1'b1;
              color_waddr_o = tgt_q;
              color_wdata_o = COLOR_ON_STACK;
              top_v_d       = tgt_q;
              top_cur_d     = head_rdata_i;
              depth_d       = depth_q + CW'(1);
            end
          end
          COLOR_ON_STACK: begin
            cyc_d   = 1'b1;
            state_d = ST_FINISH;
          end
          default: begin
          end
        endcase
      end
      ST_FINISH: begin
        if (!out_v_q) begin
          out_v_d   = 1'b1;
          out_cyc_d = cyc_q;
          out_st_d  = err_q;
          clr_d     = '0;
          state_d   = ST_CLEAR;
        end
      end
      default: begin
        clr_d   = '0;
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      stored_q <= '0;
      err_q    <= STATUS_OK;
      depth_q  <= '0;
      ld_v_q   <= 1'b0;
      fwd_v_q  <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      stored_q <= stored_d;
      err_q    <= err_d;
      depth_q  <= depth_d;
      ld_v_q   <= ld_v_d;
      fwd_v_q  <= fwd_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q       <= n_d;
    root_q    <= root_d;
    top_v_q   <= top_v_d;
    top_cur_q <= top_cur_d;
    tgt_q     <= tgt_d;
    cyc_q     <= cyc_d;
    ld_src_q  <= ld_src_d;
    ld_dst_q  <= ld_dst_d;
    ld_idx_q  <= ld_idx_d;
    fwd_idx_q <= fwd_idx_d;
    out_cyc_q <= out_cyc_d;
    out_st_q  <= out_st_d;
  end

  a_load_write_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld_v_q |-> (state_q == ST_LOAD || state_q == ST_WAIT))
    else $error("edge store write outside loading");

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= VMAX)
    else $error("walk stack depth beyond vertex count");

  a_stored_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stored_q <= EDGE_NULL)
    else $error("edge count beyond store size");

  a_last_stops_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && edge_i.last_edge) |=> !edge_i.ready)
    else $error("item taken after the last edge");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && !out_v_q) |=> (out_v_q && state_q == ST_CLEAR))
    else $error("result not registered at end of search");

endmodule

// ----- hdl/directed_cycle_detect.sv -----
// Directed graph cycle detector. Edges arrive one item per cycle on edge_i and are linked into
// per-vertex adjacency lists held in on-chip memories; an edge outside the configured vertex
// count or beyond the edge store is dropped and flagged in status. The item carrying last_edge
// starts, unless an edge was dropped, a depth-first search over the vertices below the vertex
// count, with three colours and a walk stack in memory; no further item is taken until the
// single result on result_o has been produced and the stores cleared. The memories have
// registered reads. After reset and after each result a clearing pass over all MAX_VERTICES
// head and colour entries runs before the next edge is accepted; vertex_count may be written
// at any time and applies to edges taken afterwards.
module directed_cycle_detect #(
  parameter int unsigned MAX_VERTICES = dcd_pkg::DEF_MAX_VERTICES,
  parameter int unsigned MAX_EDGES    = dcd_pkg::DEF_MAX_EDGES
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [dcd_pkg::VERTEX_COUNT_W-1:0]  cfg_wdata_i,
  dcd_edge_if.sink                            edge_i,
  dcd_result_if.source                        result_o
);
  import dcd_pkg::*;

  localparam int unsigned VW  = $clog2(MAX_VERTICES);
  localparam int unsigned CW  = $clog2(MAX_VERTICES + 1);
  localparam int unsigned EW  = $clog2(MAX_EDGES + 1);
  localparam int unsigned EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned NW  = (CW > VERTEX_COUNT_W) ? CW : VERTEX_COUNT_W;

  logic [VERTEX_COUNT_W-1:0] vertex_count_q;
  logic [NW-1:0]             count_ext;
  logic [CW-1:0]             vcount;

  logic              head_we, color_we, edge_we, stack_we;
  logic [VW-1:0]     head_waddr, head_raddr, color_waddr, color_raddr;
  logic [VW-1:0]     stack_waddr, stack_raddr;
  logic [EW-1:0]     head_wdata, head_rdata;
  logic [1:0]        color_wdata, color_rdata;
  logic [EAW-1:0]    edge_waddr, edge_raddr;
  logic [EW+VW-1:0]  edge_wdata, edge_rdata;
  logic [VW+EW-1:0]  stack_wdata, stack_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count_q <= VERTEX_COUNT_RESET;
    end else if (cfg_we_i) begin
      vertex_count_q <= cfg_wdata_i;
    end
  end

  // zero acts as one, anything above the vertex store acts as its size
  assign count_ext = NW'(vertex_count_q);
  always_comb begin
    priority if (count_ext == '0) begin
      vcount = CW'(1);
    end else if (count_ext > NW'(MAX_VERTICES)) begin
      vcount = CW'(MAX_VERTICES);
    end else begin
      vcount = count_ext[CW-1:0];
    end
  end

  dcd_ctrl #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .vcount_i      (vcount),
    .edge_i        (edge_i),
    .result_o      (result_o),
    .head_we_o     (head_we),
    .head_waddr_o  (head_waddr),
    .head_wdata_o  (head_wdata),
    .head_raddr_o  (head_raddr),
    .head_rdata_i  (head_rdata),
    .color_we_o    (color_we),
    .color_waddr_o (color_waddr),
    .color_wdata_o (color_wdata),
    .color_raddr_o (color_raddr),
    .color_rdata_i (color_rdata),
    .edge_we_o     (edge_we),
    .edge_waddr_o  (edge_waddr),
    .edge_wdata_o  (edge_wdata),
    .edge_raddr_o  (edge_raddr),
    .edge_rdata_i  (edge_rdata),
    .stack_we_o    (stack_we),
    .stack_waddr_o (stack_waddr),
    .stack_wdata_o (stack_wdata),
    .stack_raddr_o (stack_raddr),
    .stack_rdata_i (stack_rdata)
  );

  dcd_ram #(.WIDTH(EW), .DEPTH(MAX_VERTICES)) u_head_ram (
    .clk_i   (clk_i),
    .we_i    (head_we),
    .waddr_i (head_waddr),
    .wdata_i (head_wdata),
    .raddr_i (head_raddr),
    .rdata_o (head_rdata)
  );

  dcd_ram #(.WIDTH(2), .DEPTH(MAX_VERTICES)) u_color_ram (
    .clk_i   (clk_i),
    .we_i    (color_we),
    .waddr_i (color_waddr),
    .wdata_i (color_wdata),
    .raddr_i (color_raddr),
    .rdata_o (color_rdata)
  );

  dcd_ram #(.WIDTH(EW + VW), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (edge_we),
    .waddr_i (edge_waddr),
    .wdata_i (edge_wdata),
    .raddr_i (edge_raddr),
    .rdata_o (edge_rdata)
  );

  dcd_ram #(.WIDTH(VW + EW), .DEPTH(MAX_VERTICES)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stack_we),
    .waddr_i (stack_waddr),
    .wdata_i (stack_wdata),
    .raddr_i (stack_raddr),
    .rdata_o (stack_rdata)
  );

endmodule
